[sv/sar_pkg.sv]
// Shared types and constants of the scroll and address register unit.
package sar_pkg;

  localparam int AddrW  = 15;
  localparam int DelayW = 4;

  typedef enum logic [2:0] {
    OP_REG_WRITE   = 3'd0,
    OP_STATUS_READ = 3'd1,
    OP_DATA_ACCESS = 3'd2,
    OP_INC_X       = 3'd3,
    OP_INC_Y       = 3'd4,
    OP_RELOAD_H    = 3'd5,
    OP_RELOAD_V    = 3'd6,
    OP_TICK        = 3'd7
  } sar_op_e;

  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDRESS = 3'd6;

  localparam logic [13:0] NT_BASE   = 14'h2000;
  localparam logic [13:0] ATTR_BASE = 14'h23C0;
  localparam logic [4:0]  ROW_WRAP  = 5'd29;
  localparam logic [4:0]  ROW_LAST  = 5'd31;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] reg_select;
    logic [7:0] data;
    logic       rendering;
  } sar_item_t;

  typedef struct packed {
    logic [AddrW-1:0]  cur;
    logic [AddrW-1:0]  tmp;
    logic [2:0]        fine_x;
    logic              toggle;
    logic              step_row;
    logic [DelayW-1:0] delay;
  } sar_state_t;

  typedef struct packed {
    logic [AddrW-1:0] vram_address;
    logic [AddrW-1:0] temp_address;
    logic [2:0]       fine_x;
    logic             toggle;
    logic [13:0]      nametable_address;
    logic [13:0]      attr_address;
    logic [2:0]       attr_shift;
    logic [4:0]       latch_low_bits;
  } sar_result_t;

endpackage

[sv/scroll_address_registers.sv]
// Top level of the scroll and address register unit.
//
// Scroll and address register unit: keeps the current and temporary video
// addresses, fine X, the write toggle, the increment step and the delayed
// address copy count. Each input transfer carries one event (register write,
// status read, data access, coarse-X or Y increment, reload, tick) and yields
// exactly one result transfer with the state after that event. One item is
// taken every clock while the result register is free; an item passes the
// input register, then the result register fed by the single-pass next-state
// logic. The state update loop runs through the state register and sar_step.
module scroll_address_registers #(
  parameter int UPDATE_DELAY = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [2:0]  reg_select_i,
  input  logic [7:0]  data_i,
  input  logic        rendering_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [14:0] vram_address_o,
  output logic [14:0] temp_address_o,
  output logic [2:0]  fine_x_o,
  output logic        toggle_o,
  output logic [13:0] nametable_address_o,
  output logic [13:0] attr_address_o,
  output logic [2:0]  attr_shift_o,
  output logic [4:0]  latch_low_bits_o
);
  import sar_pkg::*;

  // Input register stage.
  logic      in_valid_q;
  sar_item_t in_item_q;

  // Architectural state and its next value.
  sar_state_t state_q;
  sar_state_t state_d;

  // Result register stage.
  logic        out_valid_q;
  sar_result_t out_q;
  sar_result_t out_d;

  logic out_free;
  logic advance;

  // The result slot is free when empty or when its transfer completes now.
  assign out_free   = !out_valid_q || !out_stall_i;
  // Move the held item through the update logic into the result register.
  assign advance    = in_valid_q && out_free;
  // Hold off the source only when the input register is full and stuck.
  assign in_stall_o = in_valid_q && !out_free;

  sar_step #(
    .UPDATE_DELAY(UPDATE_DELAY)
  ) u_step (
    .state_i (state_q),
    .item_i  (in_item_q),
    .state_o (state_d),
    .result_o(out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      // Commit the state only when the item leaves the input register.
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q.op         <= op_i;
      in_item_q.reg_select <= reg_select_i;
      in_item_q.data       <= data_i;
      in_item_q.rendering  <= rendering_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign vram_address_o      = out_q.vram_address;
  assign temp_address_o      = out_q.temp_address;
  assign fine_x_o            = out_q.fine_x;
  assign toggle_o            = out_q.toggle;
  assign nametable_address_o = out_q.nametable_address;
  assign attr_address_o      = out_q.attr_address;
  assign attr_shift_o        = out_q.attr_shift;
  assign latch_low_bits_o    = out_q.latch_low_bits;

  // The delayed copy count never rises above its load value.
  a_delay_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.delay <= DelayW'(UPDATE_DELAY))
    else $error("delay count above load value");

  // State changes only when an item moves into the result register.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without an item");

  // An empty input register never stalls the source.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("stall with empty input register");

endmodule

[sv/sar_step.sv]
// Next-state and result logic for one item of the scroll and address unit.
module sar_step #(
  parameter int UPDATE_DELAY = 2
) (
  input  sar_pkg::sar_state_t  state_i,
  input  sar_pkg::sar_item_t   item_i,
  output sar_pkg::sar_state_t  state_o,
  output sar_pkg::sar_result_t result_o
);
  import sar_pkg::*;

  function automatic logic [AddrW-1:0] inc_x(input logic [AddrW-1:0] v);
    logic [AddrW-1:0] r;
    if (v[4:0] == 5'h1F) begin
      r = v ^ 15'h041F;
    end else begin
      r = v + 15'd1;
    end
    return r;
  endfunction

  function automatic logic [AddrW-1:0] inc_y(input logic [AddrW-1:0] v);
    logic [AddrW-1:0] r;
    logic [AddrW-1:0] w;
    w = {3'b000, v[11:0]};
    if (v[14:12] == 3'd7) begin
      if (v[9:5] == ROW_WRAP) begin
        r = w ^ 15'h0BA0;
      end else if (v[9:5] == ROW_LAST) begin
        r = w ^ 15'h03E0;
      end else begin
        r = w + 15'h0020;
      end
    end else begin
      r = v + 15'h1000;
    end
    return r;
  endfunction

  sar_state_t       s;
  logic [DelayW-1:0] dec;
  logic [AddrW-1:0]  v;

  assign dec = state_i.delay - DelayW'(1);

  always_comb begin
    s = state_i;
    unique case (sar_op_e'(item_i.op))
      OP_REG_WRITE: begin
        case (item_i.reg_select)
          REG_CONTROL: begin
            s.step_row  = item_i.data[2];
            s.tmp[11:10] = item_i.data[1:0];
          end
          REG_SCROLL: begin
            if (!state_i.toggle) begin
              s.tmp[4:0] = item_i.data[7:3];
              s.fine_x   = item_i.data[2:0];
            end else begin
              s.tmp[9:5]   = item_i.data[7:3];
              s.tmp[14:12] = item_i.data[2:0];
            end
            s.toggle = ~state_i.toggle;
          end
          REG_ADDRESS: begin
            if (!state_i.toggle) begin
              s.tmp[13:8] = item_i.data[5:0];
              s.tmp[14]   = 1'b0;
            end else begin
              s.tmp[7:0] = item_i.data;
              s.delay    = DelayW'(UPDATE_DELAY);
            end
            s.toggle = ~state_i.toggle;
          end
          default: ;
        endcase
      end
      OP_STATUS_READ: s.toggle = 1'b0;
      OP_DATA_ACCESS: begin
        if (item_i.rendering) begin
          s.cur = inc_y(inc_x(state_i.cur));
        end else if (state_i.step_row) begin
          s.cur = state_i.cur + 15'd32;
        end else begin
          s.cur = state_i.cur + 15'd1;
        end
      end
      OP_INC_X: s.cur = inc_x(state_i.cur);
      OP_INC_Y: s.cur = inc_y(state_i.cur);
      OP_RELOAD_H: begin
        s.cur[10]  = state_i.tmp[10];
        s.cur[4:0] = state_i.tmp[4:0];
      end
      OP_RELOAD_V: begin
        s.cur[14:11] = state_i.tmp[14:11];
        s.cur[9:5]   = state_i.tmp[9:5];
      end
      OP_TICK: begin
        if (state_i.delay != '0) begin
          s.delay = dec;
          if (dec == '0) begin
            s.cur = state_i.tmp;
          end
        end
      end
      default: ;
    endcase
  end

  assign state_o = s;
  assign v       = s.cur;

  always_comb begin
    result_o.vram_address      = v;
    result_o.temp_address      = s.tmp;
    result_o.fine_x            = s.fine_x;
    result_o.toggle            = s.toggle;
    result_o.nametable_address = NT_BASE | {2'b00, v[11:0]};
    result_o.attr_address      = ATTR_BASE | {2'b00, v[11:10], 4'b0000, v[9:7], v[4:2]};
    result_o.attr_shift        = {v[6], v[1], 1'b0};
    result_o.latch_low_bits    = s.tmp[4:0];
  end

endmodule
